### design/text_whitespace_normalizer_macros.svh
// Assertion shorthands shared by the whitespace normaliser RTL.
// No dependencies; included by the files that carry assertions.
`ifndef TEXT_WHITESPACE_NORMALIZER_MACROS_SVH
`define TEXT_WHITESPACE_NORMALIZER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define TWN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("twn: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted
`define TWN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("twn: next-cycle check failed");
`else
`define TWN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TWN_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/twn_pkg.sv
// Shared types and constants for the text whitespace normaliser.
// No dependencies; imported by every module of the block.
`default_nettype none

package twn_pkg;

	localparam int unsigned PENDING_DEPTH_DEF = 32;
	localparam int unsigned CNT_W             = 6;
	localparam int unsigned NSP_W             = 5;
	localparam int unsigned CFG_W             = 5;
	localparam int unsigned CFG_IDX_W         = 1;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SP  = 8'h20;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_EOF  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_EXPAND   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAB_COLS = 1'b1;

	localparam logic [NSP_W-1:0] TAB_COLS_RST  = 5'd4;
	localparam logic [NSP_W-1:0] TAB_COLS_ZERO = 5'd4;

	typedef struct packed {
		logic       op;
		logic [7:0] text_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       overflow;
	} out_t;

	typedef enum logic [1:0] {
		CMD_PUSH    = 2'd0,
		CMD_CHAR    = 2'd1,
		CMD_NEWLINE = 2'd2,
		CMD_EOF     = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [7:0]       byte_v;
		logic             is_tab;
		logic [NSP_W-1:0] nsp;
	} cmd_t;

endpackage

`default_nettype wire

### design/text_whitespace_normalizer.sv
// Text whitespace normaliser top level; depends on twn_pkg, twn_front, twn_queue, twn_back.
// An accepted item is registered in a queue slot, and its first result in the output register.
// The back-end sequencer handles one ordinary byte or space a cycle while the output register can
// take its byte; a byte behind a held run waits while the run is flushed ahead of it, and an
// expanded leading tab yields one space a cycle. Reset (arst_n, async, low) clears control state at
// once; the whitespace hold line, queue slots and output data are not cleared.
`default_nettype none

module text_whitespace_normalizer #(
	parameter int unsigned PENDING_DEPTH = twn_pkg::PENDING_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [twn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [twn_pkg::CFG_W-1:0]     cfg_wdata,
	// input items: text bytes and end of file
	input  logic                          text_valid,
	output logic                          text_ready,
	input  twn_pkg::in_t                  text_item,
	// result items
	output logic                          norm_valid,
	input  logic                          norm_ready,
	output twn_pkg::out_t                 norm_item
);
	import twn_pkg::*;

	// front to queue
	logic cls_valid;
	logic cls_ready;
	cmd_t cls_cmd;

	// queue to back
	logic head_valid;
	logic head_ready;
	cmd_t head_cmd;

	// Classify each accepted item into a command; track CR and indentation state,
	// drop an LF that follows a CR without queueing anything.
	twn_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text_item  (text_item),
		.cmd_valid  (cls_valid),
		.cmd_ready  (cls_ready),
		.cmd        (cls_cmd)
	);

	// Hold up to two commands so the front keeps taking items while the back
	// works through a flush or a tab expansion.
	twn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cls_valid),
		.push_ready (cls_ready),
		.push_cmd   (cls_cmd),
		.pop_valid  (head_valid),
		.pop_ready  (head_ready),
		.pop_cmd    (head_cmd)
	);

	// Carry out commands: hold whitespace runs, flush them ahead of a visible
	// byte, drop them at line ends, spill the oldest entry on overflow, and
	// add the final LF at end of file. The output register holds a stalled result;
	// commands that must emit then wait, and the front halts once the queue fills.
	twn_back #(
		.PENDING_DEPTH (PENDING_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (head_valid),
		.cmd_ready  (head_ready),
		.cmd        (head_cmd),
		.norm_valid (norm_valid),
		.norm_ready (norm_ready),
		.norm_item  (norm_item)
	);

endmodule

`default_nettype wire

### design/twn_front.sv
// Front end: configuration registers, input acceptance and byte classification.
// Depends on twn_pkg.
`default_nettype none

module twn_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [twn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [twn_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         text_valid,
	output logic                         text_ready,
	input  twn_pkg::in_t                 text_item,
	output logic                         cmd_valid,
	input  logic                         cmd_ready,
	output twn_pkg::cmd_t                cmd
);
	import twn_pkg::*;

	logic             expand_q;
	logic [NSP_W-1:0] tab_cols_q;
	logic             cr_seen_q;
	logic             in_indent_q;
	logic             accept;
	logic             is_eof;
	logic             swallow;

	assign is_eof     = text_item.op == OP_EOF;
	// LF straight after CR: its LF has already gone out
	assign swallow    = !is_eof && (text_item.text_byte == CH_LF) && cr_seen_q;
	assign text_ready = cmd_ready;
	assign cmd_valid  = text_valid && !swallow;
	assign accept     = text_valid && text_ready;

	always_comb begin
		cmd.kind   = CMD_CHAR;
		cmd.byte_v = text_item.text_byte;
		cmd.is_tab = 1'b0;
		cmd.nsp    = 5'd1;
		if (is_eof) begin
			cmd.kind = CMD_EOF;
		end else begin
			case (text_item.text_byte)
				CH_LF, CH_CR: begin
					cmd.kind = CMD_NEWLINE;
				end
				CH_SP: begin
					cmd.kind = CMD_PUSH;
				end
				CH_TAB: begin
					cmd.kind = CMD_PUSH;
					if (in_indent_q && expand_q) begin
						cmd.nsp = (tab_cols_q == '0) ? TAB_COLS_ZERO : tab_cols_q;
					end else begin
						cmd.is_tab = 1'b1;
					end
				end
				default: begin
					cmd.kind = CMD_CHAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expand_q   <= 1'b0;
			tab_cols_q <= TAB_COLS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EXPAND:   expand_q   <= cfg_wdata[0];
				CFG_TAB_COLS: tab_cols_q <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_seen_q   <= 1'b0;
			in_indent_q <= 1'b1;
		end else if (accept) begin
			if (is_eof) begin
				cr_seen_q   <= 1'b0;
				in_indent_q <= 1'b1;
			end else begin
				cr_seen_q <= text_item.text_byte == CH_CR;
				if (text_item.text_byte == CH_LF || text_item.text_byte == CH_CR) begin
					in_indent_q <= 1'b1;
				end else if (text_item.text_byte != CH_SP && text_item.text_byte != CH_TAB) begin
					in_indent_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

### design/twn_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on twn_pkg.
`default_nettype none

module twn_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  twn_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output twn_pkg::cmd_t pop_cmd
);
	import twn_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = fill_q != 2'd2;
	assign pop_valid  = fill_q != 2'd0;
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### design/twn_back.sv
// Back end: whitespace hold line, command sequencer and output register.
// Depends on twn_pkg and text_whitespace_normalizer_macros.svh.
`default_nettype none
`include "text_whitespace_normalizer_macros.svh"

module twn_back #(
	parameter int unsigned PENDING_DEPTH = twn_pkg::PENDING_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  twn_pkg::cmd_t cmd,
	output logic          norm_valid,
	input  logic          norm_ready,
	output twn_pkg::out_t norm_item
);
	import twn_pkg::*;

	localparam int unsigned        IDX_W     = $clog2(PENDING_DEPTH);
	localparam logic [CNT_W-1:0]   DEPTH_CNT = CNT_W'(PENDING_DEPTH);
	localparam logic [IDX_W-1:0]   TOP_IDX   = IDX_W'(PENDING_DEPTH - 1);

	logic [PENDING_DEPTH-1:0] pend_q;
	logic [PENDING_DEPTH-1:0] pend_d;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         cnt_d;
	logic [NSP_W-1:0]         step_q;
	logic                     emitted_q;
	logic                     last_nl_q;
	logic                     out_valid_q;
	out_t                     out_q;

	logic             can_emit;
	logic             full;
	logic             need_lf;
	logic             last_push;
	logic             emit;
	logic [7:0]       emit_byte;
	logic             emit_last;
	logic             emit_ovf;
	logic             pop;
	logic             step_inc;
	logic             shift;
	logic             wr;
	logic [IDX_W-1:0] wr_idx;
	logic             clear;
	logic [7:0]       head_ws;

	assign can_emit  = !out_valid_q || norm_ready;
	assign full      = cnt_q == DEPTH_CNT;
	assign need_lf   = emitted_q && !last_nl_q;
	assign last_push = step_q == (cmd.nsp - 5'd1);
	assign head_ws   = pend_q[0] ? CH_TAB : CH_SP;
	assign wr_idx    = full ? TOP_IDX : cnt_q[IDX_W-1:0];

	always_comb begin
		emit      = 1'b0;
		emit_byte = CH_LF;
		emit_last = 1'b0;
		emit_ovf  = 1'b0;
		pop       = 1'b0;
		step_inc  = 1'b0;
		shift     = 1'b0;
		wr        = 1'b0;
		clear     = 1'b0;
		cnt_d     = cnt_q;
		if (cmd_valid) begin
			case (cmd.kind)
				CMD_PUSH: begin
					// one push a cycle unless a full line must wait for the output; a full line spills its oldest entry
					if (!full || can_emit) begin
						wr = 1'b1;
						if (full) begin
							emit      = 1'b1;
							emit_byte = head_ws;
							emit_ovf  = 1'b1;
							emit_last = last_push;
							shift     = 1'b1;
						end else begin
							cnt_d = cnt_q + 6'd1;
						end
						if (last_push) pop = 1'b1;
						else           step_inc = 1'b1;
					end
				end
				CMD_CHAR: begin
					if (can_emit) begin
						emit = 1'b1;
						if (cnt_q != '0) begin
							emit_byte = head_ws;
							shift     = 1'b1;
							cnt_d     = cnt_q - 6'd1;
						end else begin
							emit_byte = cmd.byte_v;
							emit_last = 1'b1;
							pop       = 1'b1;
						end
					end
				end
				CMD_NEWLINE: begin
					if (can_emit) begin
						emit      = 1'b1;
						emit_last = 1'b1;
						cnt_d     = '0;
						pop       = 1'b1;
					end
				end
				CMD_EOF: begin
					if (!need_lf || can_emit) begin
						emit      = need_lf;
						emit_last = 1'b1;
						cnt_d     = '0;
						clear     = 1'b1;
						pop       = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		pend_d = shift ? (pend_q >> 1) : pend_q;
		if (wr) pend_d[wr_idx] = cmd.is_tab;
	end

	assign cmd_ready  = pop;
	assign norm_valid = out_valid_q;
	assign norm_item  = out_q;

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (emit) begin
			out_q.out_byte <= emit_byte;
			out_q.last     <= emit_last;
			out_q.overflow <= emit_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			step_q      <= '0;
			emitted_q   <= 1'b0;
			last_nl_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			if (pop)           step_q <= '0;
			else if (step_inc) step_q <= step_q + 5'd1;
			// end of file wins over the final LF it may emit
			if (clear) begin
				emitted_q <= 1'b0;
				last_nl_q <= 1'b0;
			end else if (emit) begin
				emitted_q <= 1'b1;
				last_nl_q <= emit_byte == CH_LF;
			end
			if (emit)            out_valid_q <= 1'b1;
			else if (norm_ready) out_valid_q <= 1'b0;
		end
	end

	`TWN_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= DEPTH_CNT)
	`TWN_ASSERT_IMP(a_ovf_full, clk, arst_n, emit && emit_ovf, full && cmd.kind == CMD_PUSH)
	`TWN_ASSERT_NXT(a_eof_clear, clk, arst_n, pop && cmd.kind == CMD_EOF, cnt_q == '0 && !emitted_q && !last_nl_q)
	`TWN_ASSERT_NXT(a_nl_mark, clk, arst_n, pop && cmd.kind == CMD_NEWLINE, last_nl_q && cnt_q == '0)

endmodule

`default_nettype wire

### tb/sv/text_whitespace_normalizer_tb.sv
// Self-checking testbench for text_whitespace_normalizer: directed and random text streams.
// Depends on twn_pkg and the RTL; a scoreboard class predicts every normalised byte and
// checks the result channel against it.

module text_whitespace_normalizer_tb;
	import twn_pkg::*;

	localparam int unsigned HOLD_DEPTH      = PENDING_DEPTH_DEF;
	localparam int unsigned PLAIN_TAB_COLS  = 4;   // a tab width of zero falls back to this
	localparam int          SETTLE_CYCLES   = 48;  // covers the longest run with no output
	localparam int          STUCK_LIMIT     = 4000;
	localparam int          PHASE_ITEMS     = 45;
	localparam int          PHASE_COUNT     = 6;
	localparam int          REPORT_LINES    = 40;

	// Receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN  = 2'd0,
		RX_COIN  = 2'd1,
		RX_CHOKE = 2'd2,
		RX_BEAT  = 2'd3
	} rx_mode_t;

	// Predicts the normalised byte stream and holds the bytes still owed by the block
	class ws_norm_checker;
		bit          expand_tabs;
		logic [4:0]  tab_cols;
		bit          held_is_tab[$];   // whitespace run waiting for a non-blank byte
		bit          cr_pending;
		bit          at_indent;
		bit          wrote_any;
		bit          wrote_lf;
		out_t        expected_bytes[$];
		int          mismatches;
		int          n_checked;

		function new();
			expand_tabs = 1'b0;
			tab_cols    = 5'd4;
			mismatches  = 0;
			n_checked   = 0;
			restart();
		endfunction

		function void restart();
			held_is_tab.delete();
			cr_pending = 1'b0;
			at_indent  = 1'b1;
			wrote_any  = 1'b0;
			wrote_lf   = 1'b0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == CFG_EXPAND) begin
				expand_tabs = data[0];
			end else begin
				tab_cols = data;
			end
		endfunction

		function void owe_byte(logic [7:0] b, bit ovf);
			out_t r;
			r.out_byte = b;
			r.last     = 1'b0;
			r.overflow = ovf;
			expected_bytes.push_back(r);
			wrote_any = 1'b1;
			wrote_lf  = (b == CH_LF);
		endfunction

		// Hold one blank; a full store lets its oldest byte out early
		function void hold_blank(bit is_tab);
			if (held_is_tab.size() >= HOLD_DEPTH) begin
				owe_byte(held_is_tab.pop_front() ? CH_TAB : CH_SP, 1'b1);
			end
			held_is_tab.push_back(is_tab);
		endfunction

		function void line_break();
			held_is_tab.delete();
			owe_byte(CH_LF, 1'b0);
			at_indent = 1'b1;
		endfunction

		function void predict(in_t it);
			int   n_before;
			int   cols;
			bit   was_cr;
			out_t tail;
			n_before = expected_bytes.size();
			if (it.op == OP_EOF) begin
				held_is_tab.delete();
				if (wrote_any && !wrote_lf) begin
					owe_byte(CH_LF, 1'b0);
				end
				restart();
			end else begin
				was_cr     = cr_pending;
				cr_pending = 1'b0;
				case (it.text_byte)
					CH_LF: begin
						if (!was_cr) begin
							line_break();
						end
					end
					CH_CR: begin
						line_break();
						cr_pending = 1'b1;
					end
					CH_SP: begin
						hold_blank(1'b0);
					end
					CH_TAB: begin
						if (at_indent && expand_tabs) begin
							cols = (tab_cols == 0) ? PLAIN_TAB_COLS : int'(tab_cols);
							repeat (cols) hold_blank(1'b0);
						end else begin
							hold_blank(1'b1);
						end
					end
					default: begin
						at_indent = 1'b0;
						for (int i = 0; i < held_is_tab.size(); i++) begin
							owe_byte(held_is_tab[i] ? CH_TAB : CH_SP, 1'b0);
						end
						held_is_tab.delete();
						owe_byte(it.text_byte, 1'b0);
					end
				endcase
			end
			// Mark the final byte that this item caused
			if (expected_bytes.size() > n_before) begin
				tail      = expected_bytes.pop_back();
				tail.last = 1'b1;
				expected_bytes.push_back(tail);
			end
		endfunction

		task report(string msg);
			if (mismatches < REPORT_LINES) begin
				$display("MISMATCH at %0t: %s", $time, msg);
			end
			mismatches++;
		endtask

		task check_result(out_t got);
			out_t want;
			if (expected_bytes.size() == 0) begin
				report($sformatf("result %0d byte %02h arrived with nothing owed",
					n_checked, got.out_byte));
			end else begin
				want = expected_bytes.pop_front();
				if (got.out_byte !== want.out_byte)
					report($sformatf("result %0d out_byte %02h, wanted %02h",
						n_checked, got.out_byte, want.out_byte));
				if (got.last !== want.last)
					report($sformatf("result %0d last %b, wanted %b",
						n_checked, got.last, want.last));
				if (got.overflow !== want.overflow)
					report($sformatf("result %0d overflow %b, wanted %b",
						n_checked, got.overflow, want.overflow));
			end
			n_checked++;
		endtask
	endclass

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = CFG_EXPAND;
	logic [CFG_W-1:0]     cfg_wdata   = '0;
	logic                 text_valid  = 1'b0;
	logic                 text_ready;
	in_t                  text_item   = '0;
	logic                 norm_valid;
	logic                 norm_ready  = 1'b0;
	out_t                 norm_item;

	ws_norm_checker sb = new();

	int       stuck_cycles = 0;
	int       burst_left   = 0;
	bit       calm         = 1'b0;   // no sender gaps while set
	int       phase_sent   = 0;
	rx_mode_t rx_mode      = RX_OPEN;
	int       rx_left      = 0;
	int       rx_beat      = 0;

	text_whitespace_normalizer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text_item  (text_item),
		.norm_valid (norm_valid),
		.norm_ready (norm_ready),
		.norm_item  (norm_item)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Observe both channels and the register port at every rising edge; predict before
	// checking so that ordering within the edge never matters.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.set_reg(cfg_index, cfg_wdata);
			if (text_valid && text_ready)
				sb.predict(text_item);
			if (norm_valid && norm_ready)
				sb.check_result(norm_item);
			if ((text_valid && text_ready) || (norm_valid && norm_ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		// Give up when neither channel has moved for far too long
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Receiver: switch between randomly chosen stall patterns
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 96);
		end else begin
			rx_left--;
		end
		rx_beat++;
		case (rx_mode)
			RX_OPEN:  norm_ready <= 1'b1;
			RX_COIN:  norm_ready <= 1'($urandom_range(0, 1));
			RX_CHOKE: norm_ready <= ($urandom_range(0, 5) == 0);
			RX_BEAT:  norm_ready <= (rx_beat % 4 != 3);
			default:  norm_ready <= 1'b1;
		endcase
	end

	// Offer one item from a falling edge and hold it until accepted; end on a falling edge.
	// Gaps fall only at the start of a burst.
	task send_item(in_t it);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (!calm && $urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 5);
		end
		burst_left--;
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_valid <= 1'b1;
		text_item  <= it;
		do @(posedge clk); while (!text_ready);
		phase_sent++;
		@(negedge clk);
	endtask

	task send_byte(logic [7:0] b);
		in_t it;
		it.op        = OP_BYTE;
		it.text_byte = b;
		send_item(it);
	endtask

	// The byte field rides along with end of file and must be ignored
	task send_eof(logic [7:0] junk);
		in_t it;
		it.op        = OP_EOF;
		it.text_byte = junk;
		send_item(it);
	endtask

	task send_blank();
		send_byte($urandom_range(0, 1) ? CH_TAB : CH_SP);
	endtask

	// Any byte that is neither blank nor a line ending, mostly printable
	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		do begin
			if ($urandom_range(0, 1))
				b = 8'($urandom_range(8'h21, 8'h7E));
			else
				b = 8'($urandom_range(0, 255));
		end while (b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF);
		return b;
	endfunction

	// Indentation, words, trailing blanks and one of the three line endings
	task send_line();
		int n_words;
		repeat ($urandom_range(0, 4)) send_blank();
		n_words = $urandom_range(1, 3);
		for (int w = 0; w < n_words; w++) begin
			if (w > 0)
				repeat ($urandom_range(1, 2)) send_blank();
			repeat ($urandom_range(1, 4)) send_byte(word_byte());
		end
		repeat ($urandom_range(0, 3)) send_blank();
		case ($urandom_range(0, 2))
			0: send_byte(CH_LF);
			1: send_byte(CH_CR);
			default: begin
				send_byte(CH_CR);
				send_byte(CH_LF);
			end
		endcase
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Drop valid, wait for every owed byte, then let any silent work finish
	task wait_idle();
		text_valid <= 1'b0;
		while (sb.expected_bytes.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [CFG_W-1:0] width_pick [PHASE_COUNT];
		bit               expand_pick[PHASE_COUNT];
		width_pick  = '{5'd1, 5'd16, 5'd31, 5'd2, 5'd7, 5'd0};
		expand_pick = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: plain text, blanks flushed before a byte, CRLF swallowing,
		// trailing blanks dropped, control bytes passed, final LF added once
		send_byte(8'h41);
		send_byte(CH_SP);
		send_byte(CH_TAB);
		send_byte(8'h62);
		send_byte(CH_SP);
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(CH_LF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_TAB);
		send_byte(CH_SP);
		send_eof(8'hFF);
		send_eof(8'h00);
		wait_idle();

		// Expanded leading tab with zero width, which counts as four
		write_reg(CFG_EXPAND, 5'd1);
		write_reg(CFG_TAB_COLS, 5'd0);
		send_byte(CH_TAB);
		send_byte(CH_SP);
		send_byte(8'h78);
		send_eof(8'h00);
		wait_idle();

		// Widest tab: two of them overflow the hold store; lone CR before a byte
		write_reg(CFG_TAB_COLS, 5'd31);
		send_byte(CH_TAB);
		send_byte(CH_TAB);
		send_byte(8'h79);
		send_byte(CH_CR);
		send_byte(8'h7A);
		send_byte(CH_LF);
		send_eof(8'h00);
		wait_idle();

		// Random phases, each under its own register settings
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			if (ph == PHASE_COUNT - 1) begin
				write_reg(CFG_EXPAND, 5'($urandom_range(0, 1)));
				write_reg(CFG_TAB_COLS, 5'($urandom_range(0, 31)));
			end else begin
				write_reg(CFG_EXPAND, {4'd0, expand_pick[ph]});
				write_reg(CFG_TAB_COLS, width_pick[ph]);
			end
			calm       = (ph % 3 == 1);
			phase_sent = 0;
			while (phase_sent < PHASE_ITEMS) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: send_line();
					6: begin
						// Long blank run, which can push the hold store past full
						repeat ($urandom_range(30, 36)) send_blank();
						send_byte(word_byte());
					end
					7: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
					8: send_eof(8'($urandom_range(0, 255)));
					default: begin
						if ($urandom_range(0, 1)) begin
							send_byte(CH_CR);
							send_byte(word_byte());
						end else begin
							send_byte(CH_LF);
							send_byte(CH_LF);
						end
					end
				endcase
			end
			wait_idle();
		end

		if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
